>>> rtl/lts_pkg.sv
// Shared types and constants for the locale tag case checker.
// Used by lts_step and language_tag_case_validator_core; no dependencies.
package lts_pkg;

    localparam int MAX_TAG_LENGTH    = 63;
    localparam int MAX_SUBTAG_LENGTH = 8;

    localparam int TOTAL_W = 7;
    localparam int SUB_W   = 4;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;
    localparam logic [SUB_W-1:0]   SUB_SAT   = '1;

    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_length;
        logic [SUB_W-1:0]   subtag_length;
        logic               in_first_subtag;
        logic               failed;
        logic               sub_has_upper;
        logic               sub_has_lower;
        logic               sub_has_digit;
        logic               sub_lead_is_lower;
        logic               sub_tail_has_upper;
    } t_tag_state;

    localparam t_tag_state TAG_STATE_RESET = '{
        total_length:       '0,
        subtag_length:      '0,
        in_first_subtag:    1'b1,
        failed:             1'b0,
        sub_has_upper:      1'b0,
        sub_has_lower:      1'b0,
        sub_has_digit:      1'b0,
        sub_lead_is_lower:  1'b0,
        sub_tail_has_upper: 1'b0
    };

endpackage

>>> rtl/lts_step.sv
// Next-state logic for one tag byte: classify the byte, update the subtag
// flags and counters, and judge the tag on its last byte. Uses lts_pkg.
module lts_step (
    input  lts_pkg::t_tag_state i_state,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    output lts_pkg::t_tag_state o_state,
    output logic                o_tag_valid
);

    // Rules for the subtag that just ended
    function automatic logic subtag_ok(input lts_pkg::t_tag_state s);
        logic ok;
        begin
            ok = 1'b0;
            if (s.subtag_length == '0 ||
                s.subtag_length > lts_pkg::SUB_W'(lts_pkg::MAX_SUBTAG_LENGTH)) begin
                ok = 1'b0;
            end else if (s.in_first_subtag) begin
                ok = (s.subtag_length >= lts_pkg::SUB_W'(2)) &&
                     !s.sub_has_digit && !s.sub_has_upper;
            end else if (s.subtag_length == lts_pkg::SUB_W'(2)) begin
                ok = !s.sub_has_lower;
            end else if (s.subtag_length == lts_pkg::SUB_W'(4)) begin
                ok = !s.sub_lead_is_lower && !s.sub_tail_has_upper;
            end else begin
                ok = !s.sub_has_upper;
            end
            subtag_ok = ok;
        end
    endfunction

    logic               is_up;
    logic               is_lo;
    logic               is_dg;
    lts_pkg::t_tag_state s_mid;

    assign is_up = (i_char >= lts_pkg::CHAR_UPPER_A) && (i_char <= lts_pkg::CHAR_UPPER_Z);
    assign is_lo = (i_char >= lts_pkg::CHAR_LOWER_A) && (i_char <= lts_pkg::CHAR_LOWER_Z);
    assign is_dg = (i_char >= lts_pkg::CHAR_DIGIT_0) && (i_char <= lts_pkg::CHAR_DIGIT_9);

    always_comb begin
        s_mid = i_state;
        if ({1'b0, i_state.total_length} >= 8'(lts_pkg::MAX_TAG_LENGTH)) begin
            s_mid.failed = 1'b1;
        end
        if (i_state.total_length < lts_pkg::TOTAL_SAT) begin
            s_mid.total_length = i_state.total_length + lts_pkg::TOTAL_W'(1);
        end

        if (i_char == lts_pkg::CHAR_DASH) begin
            if (!subtag_ok(i_state)) begin
                s_mid.failed = 1'b1;
            end
            s_mid.subtag_length      = '0;
            s_mid.sub_has_upper      = 1'b0;
            s_mid.sub_has_lower      = 1'b0;
            s_mid.sub_has_digit      = 1'b0;
            s_mid.sub_lead_is_lower  = 1'b0;
            s_mid.sub_tail_has_upper = 1'b0;
            s_mid.in_first_subtag    = 1'b0;
        end else begin
            if (!is_up && !is_lo && !is_dg) begin
                s_mid.failed = 1'b1;
            end
            if (i_state.subtag_length == '0) begin
                if (is_lo) begin
                    s_mid.sub_lead_is_lower = 1'b1;
                end
            end else if (is_up) begin
                s_mid.sub_tail_has_upper = 1'b1;
            end
            if (is_up) begin
                s_mid.sub_has_upper = 1'b1;
            end
            if (is_lo) begin
                s_mid.sub_has_lower = 1'b1;
            end
            if (is_dg) begin
                s_mid.sub_has_digit = 1'b1;
            end
            // Hold the counter at its limit once the subtag runs long
            if (i_state.subtag_length >= lts_pkg::SUB_W'(lts_pkg::MAX_SUBTAG_LENGTH)) begin
                s_mid.failed = 1'b1;
            end else if (i_state.subtag_length < lts_pkg::SUB_SAT) begin
                s_mid.subtag_length = i_state.subtag_length + lts_pkg::SUB_W'(1);
            end
        end
    end

    always_comb begin
        o_tag_valid = !(s_mid.failed || !subtag_ok(s_mid) ||
                        (s_mid.total_length < lts_pkg::TOTAL_W'(2)));
        // Drop all tag state after the last byte
        if (i_last) begin
            o_state = lts_pkg::TAG_STATE_RESET;
        end else begin
            o_state = s_mid;
        end
    end

endmodule

>>> rtl/language_tag_case_validator_core.sv
// Top level of the locale tag case checker: input register, running tag
// state, result register. Depends on lts_pkg and lts_step.
//
//  channel | dir | tdata bits (low first) | tlast           | role
//  s       | in  | [7:0] char_byte        | last            | tag bytes
//  m       | out | [0] tag_valid, [7:1] 0 | -               | one result per tag
//
// One byte per clock unless a tag end waits on m; a byte's update is applied
// from the input register; only a tag's last byte loads the result register.
// The tag state update is the single path from the input register to the
// result register. i_rst_n is synchronous, active low, and clears the tag
// state and both valid flags. A stall on m holds the result; a tag end then
// waits in the input register with o_s_tready low, other bytes keep flowing.
module language_tag_case_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] tag_valid, [7:1] zero
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_last;
    logic                r_out_valid;
    logic                r_out_tag_valid;
    lts_pkg::t_tag_state r_state;
    lts_pkg::t_tag_state n_state;
    logic                n_tag_valid;
    logic                advance;
    logic                out_free;

    lts_step u_step (
        .i_state     (r_state),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .o_state     (n_state),
        .o_tag_valid (n_tag_valid)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= lts_pkg::TAG_STATE_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && r_in_last) begin
            r_out_tag_valid <= n_tag_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_tag_valid};

endmodule

>>> rtl/lts_checker.sv
// Port-level checks for language_tag_case_validator_core, attached by bind.
// No package dependency.
module lts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'b0))
        else $error("result padding not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A fresh result comes from a tag end accepted on s
    a_rose_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast, 2))
        else $error("result without a tag end");

endmodule

bind language_tag_case_validator_core lts_checker u_lts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
